[rtl/wwfr_pkg.sv]
// shared types, constants and helpers of the whole-word find-and-replace block
package wwfr_pkg;

    // most results that one source byte may cause
    localparam int RESULT_LIMIT = 16;
    localparam int N_W          = $clog2(RESULT_LIMIT + 1);

    // depth of the result queue in front of the output port
    localparam int OUTQ_DEPTH = 2;

    // configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_TEXT    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEARCH_LENGTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_TEXT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_WHOLE_WORD     = 3'd4;

    localparam logic [7:0] UNDERSCORE = 8'h5F;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_BURST
    } eng_state_t;

    typedef struct packed {
        logic [7:0] data;
        logic       run_last;
        logic       text_done;
    } result_t;

    // letters, digits and underscore
    function automatic logic is_word(input logic [7:0] c);
        logic lower;
        logic upper;
        logic digit;
        lower = (c >= 8'h61) && (c <= 8'h7A);
        upper = (c >= 8'h41) && (c <= 8'h5A);
        digit = (c >= 8'h30) && (c <= 8'h39);
        return lower || upper || digit || (c == UNDERSCORE);
    endfunction

    function automatic logic [7:0] byte_of(input logic [63:0] w, input logic [2:0] i);
        return w[8*i +: 8];
    endfunction

endpackage

[rtl/wwfr_cell.sv]
// one byte cell of the held-back window, with its compare and word-class flag
module wwfr_cell
    import wwfr_pkg::*;
(
    input  logic       clk,
    input  logic       adv,
    input  logic       ins,
    input  logic [7:0] ins_byte,
    input  logic       shift,
    input  logic [7:0] next_view,
    input  logic [7:0] key_byte,
    output logic [7:0] view,
    output logic       eq,
    output logic       word
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    // incoming source byte lands here when this cell is the first free one
    assign view      = ins ? ins_byte : data_reg;
    assign eq        = (view == key_byte);
    assign word      = is_word(view);
    assign data_next = shift ? next_view : view;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            data_reg <= data_next;
        end
    end

endmodule

[rtl/wwfr_out_queue.sv]
// small result queue that decouples the engine from the output port
module wwfr_out_queue
    import wwfr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_item,
    output logic    full,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_item
);

    localparam int QP_W = (OUTQ_DEPTH > 1) ? $clog2(OUTQ_DEPTH) : 1;
    localparam int QC_W = $clog2(OUTQ_DEPTH + 1);

    result_t           mem_reg [OUTQ_DEPTH];
    logic [QP_W-1:0]   wr_ptr_reg;
    logic [QP_W-1:0]   wr_ptr_next;
    logic [QP_W-1:0]   rd_ptr_reg;
    logic [QP_W-1:0]   rd_ptr_next;
    logic [QC_W-1:0]   cnt_reg;
    logic [QC_W-1:0]   cnt_next;
    logic              pop;

    assign full      = (cnt_reg == QC_W'(OUTQ_DEPTH));
    assign out_valid = (cnt_reg != '0);
    assign out_item  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QP_W'(OUTQ_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QP_W'(OUTQ_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

[rtl/whole_word_find_replace.sv]
// whole-word find-and-replace over a byte stream: top level with window control
//
// source text arrives one byte per request and leaves rewritten, one byte per
// output request; run_last marks the last byte caused by a request and text_done the
// final byte of a text. held-back bytes sit in a row of SEARCH_MAX+1 byte cells
// that compare against the search string in parallel and shift one place a cycle
// while the result queue has room; plain text passes at one byte per cycle on the
// same terms. a replaced match emits the replacement while dropping the match, a
// match left as is (word byte on either side) passes through byte by byte; both are
// set by the single output byte per cycle and the one-place shift of the cell row.
// a decision waits for the next byte when a whole-word match reaches the end of the
// window, and the window is flushed at each end of text. a byte goes out through the
// input register, cell row, last-byte hold and result queue. the user must write
// configuration only while no text byte is in flight; the block does not enforce it.
module whole_word_find_replace
    import wwfr_pkg::*;
#(
    parameter int SEARCH_MAX  = 8,
    parameter int REPLACE_MAX = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    // source text requests
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [7:0]           text_byte,
    input  logic                 end_of_text,
    // rewritten text requests
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           out_byte,
    output logic                 run_last,
    output logic                 text_done,
    // configuration writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    // window depth: a full search string plus the byte after it
    localparam int DEPTH = SEARCH_MAX + 1;
    localparam int CMAX  = (DEPTH > REPLACE_MAX) ? DEPTH : REPLACE_MAX;
    localparam int CW    = $clog2(CMAX + 1);

    // configuration registers
    logic [63:0] search_text_reg;
    logic [3:0]  search_length_reg;
    logic [63:0] replace_text_reg;
    logic [3:0]  replace_length_reg;
    logic        whole_word_reg;

    // input register
    logic        buf_valid_reg;
    logic [7:0]  buf_byte_reg;
    logic        buf_eot_reg;

    // engine state
    eng_state_t  state_reg;
    eng_state_t  state_next;
    logic [CW-1:0]  count_reg;
    logic [CW-1:0]  count_next;
    logic [7:0]     before_reg;
    logic [7:0]     before_next;
    logic           before_valid_reg;
    logic           before_valid_next;
    logic [N_W-1:0] n_reg;
    logic [N_W-1:0] n_next;
    logic [CW-1:0]  k_reg;
    logic [CW-1:0]  k_next;
    logic [CW-1:0]  blen_reg;
    logic [CW-1:0]  blen_next;
    logic           rep_reg;
    logic           rep_next;
    logic           eot_reg;
    logic           eot_next;

    // last-byte hold stage
    logic        hold_valid_reg;
    logic        hold_valid_next;
    logic [7:0]  hold_byte_reg;
    logic [7:0]  hold_byte_next;
    logic        end_reg;
    logic        end_eot_reg;

    // cell row
    logic [7:0]       view [DEPTH];
    logic [DEPTH-1:0] eq;
    logic [DEPTH-1:0] word;
    logic [DEPTH-1:0] ins;

    // control
    logic          q_full;
    logic          adv;
    logic          take;
    logic          ins_ok;
    logic [CW-1:0] count_v;
    logic          step_eot;
    logic          eval_now;
    logic          burst_now;
    logic [CW-1:0] len;
    logic [CW-1:0] rlen;
    logic          hit_cmp;
    logic          after_word;
    logic          before_word;
    logic          full_win;
    logic          hit;
    logic          have_after;
    logic          ev_brk;
    logic          ev_rep;
    logic [CW-1:0] ev_size;
    logic [CW-1:0] ev_blen;
    logic          act;
    logic          act_rep;
    logic [CW-1:0] act_k;
    logic [CW-1:0] act_blen;
    logic          emit_now;
    logic [7:0]    emit_byte;
    logic          drop_now;
    logic          unit_last;
    logic [CW-1:0] count_after;
    logic          pred_brk;
    logic          step_end;
    logic          push;
    result_t       push_item;
    result_t       out_item;

    // ------------------------------------------------------------------
    // configuration, always accepted
    // ------------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            search_text_reg    <= '0;
            search_length_reg  <= 4'd1;
            replace_text_reg   <= '0;
            replace_length_reg <= '0;
            whole_word_reg     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SEARCH_TEXT:    search_text_reg    <= cfg_data;
                CFG_SEARCH_LENGTH:  search_length_reg  <= cfg_data[3:0];
                CFG_REPLACE_TEXT:   replace_text_reg   <= cfg_data;
                CFG_REPLACE_LENGTH: replace_length_reg <= cfg_data[3:0];
                CFG_WHOLE_WORD:     whole_word_reg     <= cfg_data[0];
                default:            ;
            endcase
        end
    end

    // an empty search acts as one byte, long lengths saturate
    assign len = (search_length_reg == 4'd0)             ? CW'(1) :
                 (search_length_reg > 4'(SEARCH_MAX))    ? CW'(SEARCH_MAX) :
                                                           CW'(search_length_reg);
    assign rlen = (replace_length_reg > 4'(REPLACE_MAX)) ? CW'(REPLACE_MAX) :
                                                           CW'(replace_length_reg);

    // ------------------------------------------------------------------
    // input register and step start
    // ------------------------------------------------------------------
    assign adv      = !q_full;
    assign take     = adv && (state_reg == ST_IDLE) && buf_valid_reg;
    assign in_ready = !buf_valid_reg || take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            buf_valid_reg <= 1'b0;
        end
        else if (in_valid && in_ready)
        begin
            buf_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            buf_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            buf_byte_reg <= text_byte;
            buf_eot_reg  <= end_of_text;
        end
    end

    // a full window drops the new byte
    assign ins_ok   = take && (count_reg < CW'(DEPTH));
    assign count_v  = count_reg + CW'(ins_ok);
    assign step_eot = (state_reg == ST_IDLE) ? buf_eot_reg : eot_reg;

    // ------------------------------------------------------------------
    // row of window cells, cell 0 holds the oldest byte
    // ------------------------------------------------------------------
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [7:0] nbr;
        logic [7:0] key;

        assign ins[i] = ins_ok && (count_reg == CW'(i));

        if (i == DEPTH - 1)
        begin : g_tail
            assign nbr = 8'h00;
            assign key = 8'h00;
        end
        else
        begin : g_body
            assign nbr = view[i+1];
            assign key = search_text_reg[8*i +: 8];
        end

        wwfr_cell u_cell (
            .clk       (clk),
            .adv       (adv),
            .ins       (ins[i]),
            .ins_byte  (buf_byte_reg),
            .shift     (drop_now),
            .next_view (nbr),
            .key_byte  (key),
            .view      (view[i]),
            .eq        (eq[i]),
            .word      (word[i])
        );
    end

    // ------------------------------------------------------------------
    // match decision at the head of the window
    // ------------------------------------------------------------------
    always_comb
    begin
        hit_cmp    = 1'b1;
        after_word = 1'b0;
        for (int i = 0; i < SEARCH_MAX; i++)
        begin
            if ((CW'(i) < len) && !eq[i])
            begin
                hit_cmp = 1'b0;
            end
        end
        // byte just after the candidate match
        for (int i = 0; i < DEPTH; i++)
        begin
            if (CW'(i) == len)
            begin
                after_word = word[i];
            end
        end
    end

    assign before_word = before_valid_reg && is_word(before_reg);
    assign full_win    = (count_v >= len);
    assign hit         = full_win && hit_cmp;
    assign have_after  = (count_v > len);
    assign eval_now    = take || (adv && (state_reg == ST_RUN));
    assign burst_now   = adv && (state_reg == ST_BURST);

    always_comb
    begin
        ev_rep  = hit && !(whole_word_reg && (before_word || (have_after && after_word)));
        ev_size = hit ? (ev_rep ? rlen : len) : CW'(1);
        ev_blen = hit ? (ev_rep ? ((rlen > len) ? rlen : len) : len) : CW'(1);
        priority if (count_v == '0)
        begin
            ev_brk = 1'b1;
        end
        else if (!full_win && !step_eot)
        begin
            // could still grow into a match
            ev_brk = 1'b1;
        end
        else if (hit && whole_word_reg && !have_after && !step_eot)
        begin
            // whole-word check needs the byte after the match
            ev_brk = 1'b1;
        end
        else if (({1'b0, n_reg} + (N_W+1)'(ev_size)) > (N_W+1)'(RESULT_LIMIT))
        begin
            // unit would overrun the results of this request
            ev_brk = 1'b1;
        end
        else
        begin
            ev_brk = 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // one unit step per cycle while the result queue has room: emit one byte and/or drop one cell
    // ------------------------------------------------------------------
    assign act      = (eval_now && !ev_brk) || burst_now;
    assign act_rep  = burst_now ? rep_reg  : ev_rep;
    assign act_k    = burst_now ? k_reg    : '0;
    assign act_blen = burst_now ? blen_reg : ev_blen;

    assign emit_now  = act && (!act_rep || (act_k < rlen));
    assign emit_byte = act_rep ? byte_of(replace_text_reg, 3'(act_k)) : view[0];
    assign drop_now  = act && (!act_rep || (act_k < len));
    assign unit_last = act && (act_k == act_blen - 1'b1);

    assign count_after = count_v - CW'(drop_now);
    // next decision would only wait, so end the request now
    assign pred_brk    = unit_last &&
                         ((count_after == '0) || ((count_after < len) && !step_eot));
    assign step_end    = (eval_now && ev_brk) || pred_brk;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    state_next = step_end ? ST_IDLE : (unit_last ? ST_RUN : ST_BURST);
                end
            end
            ST_RUN, ST_BURST:
            begin
                if (adv)
                begin
                    state_next = step_end ? ST_IDLE : (unit_last ? ST_RUN : ST_BURST);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath updates
    always_comb
    begin
        count_next        = count_reg;
        before_next       = before_reg;
        before_valid_next = before_valid_reg;
        n_next            = n_reg;
        k_next            = k_reg;
        blen_next         = blen_reg;
        rep_next          = rep_reg;
        eot_next          = eot_reg;
        if (take)
        begin
            eot_next = buf_eot_reg;
        end
        if (eval_now || burst_now)
        begin
            count_next = count_after;
            n_next     = n_reg + N_W'(emit_now);
            if (drop_now)
            begin
                before_next       = view[0];
                before_valid_next = 1'b1;
            end
            if (act)
            begin
                k_next = act_k + 1'b1;
            end
            if (eval_now && !ev_brk)
            begin
                blen_next = ev_blen;
                rep_next  = ev_rep;
            end
            if (step_end)
            begin
                n_next = '0;
                if (step_eot)
                begin
                    // flush done, next text starts clean
                    count_next        = '0;
                    before_next       = 8'h00;
                    before_valid_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            count_reg        <= '0;
            before_reg       <= 8'h00;
            before_valid_reg <= 1'b0;
            n_reg            <= '0;
            k_reg            <= '0;
            blen_reg         <= '0;
            rep_reg          <= 1'b0;
            eot_reg          <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            count_reg        <= count_next;
            before_reg       <= before_next;
            before_valid_reg <= before_valid_next;
            n_reg            <= n_next;
            k_reg            <= k_next;
            blen_reg         <= blen_next;
            rep_reg          <= rep_next;
            eot_reg          <= eot_next;
        end
    end

    // ------------------------------------------------------------------
    // hold the newest byte until it is known whether it ends its request
    // ------------------------------------------------------------------
    assign push = adv && hold_valid_reg && (emit_now || end_reg);

    always_comb
    begin
        push_item.data      = hold_byte_reg;
        push_item.run_last  = end_reg;
        push_item.text_done = end_reg && end_eot_reg;
    end

    always_comb
    begin
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        if (emit_now)
        begin
            hold_valid_next = 1'b1;
            hold_byte_next  = emit_byte;
        end
        else if (push)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
            end_reg        <= 1'b0;
            end_eot_reg    <= 1'b0;
        end
        else if (adv)
        begin
            hold_valid_reg <= hold_valid_next;
            end_reg        <= step_end;
            end_eot_reg    <= step_end && step_eot;
        end
    end

    always_ff @(posedge clk)
    begin
        hold_byte_reg <= hold_byte_next;
    end

    // ------------------------------------------------------------------
    // result queue and output port
    // ------------------------------------------------------------------
    wwfr_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    assign out_byte  = out_item.data;
    assign run_last  = out_item.run_last;
    assign text_done = out_item.text_done;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("window count beyond cell row");

    a_result_bound: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= N_W'(RESULT_LIMIT))
        else $error("too many results for one request");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && step_end && step_eot) |=> ((count_reg == '0) && !before_valid_reg))
        else $error("window not cleared after end of text");

    a_burst_index: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_BURST) |-> (k_reg < blen_reg))
        else $error("burst index past burst length");

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_now && hold_valid_reg) |-> push)
        else $error("held byte overwritten without being queued");
`endif

endmodule
